>>> hdl/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, codes and constants of the supercap start-assist controller.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int ADC_W     = 12;
  localparam int TIME_W    = 22;
  localparam int STAMP_W   = 32;
  localparam int DUTY_W    = 10;
  localparam int CODE_W    = 3;
  localparam int CFG_IDX_W = 4;

  localparam int PWM_FULL_SCALE    = 800;
  localparam int STARTUP_WINDOW_MS = 500;
  localparam int COOLDOWN_MS       = 1000;

  localparam logic [DUTY_W-1:0] BOOST_START = DUTY_W'(PWM_FULL_SCALE / 2);
  localparam logic [DUTY_W-1:0] BOOST_STEP  = DUTY_W'(PWM_FULL_SCALE / 20);
  localparam logic [DUTY_W-1:0] BOOST_TOP   = DUTY_W'(PWM_FULL_SCALE * 8 / 10);
  localparam logic [DUTY_W-1:0] DUTY_MAX    = DUTY_W'(PWM_FULL_SCALE);

  localparam int CHARGE_BLINK_MS = 500;
  localparam int BOOST_BLINK_MS  = 50;
  localparam int FAULT_BLINK_MS  = 200;
  localparam int CHG_REM_W   = $clog2(CHARGE_BLINK_MS);
  localparam int BOOST_REM_W = $clog2(BOOST_BLINK_MS);
  localparam int FAULT_REM_W = $clog2(FAULT_BLINK_MS);

  // operating modes
  localparam logic [CODE_W-1:0] M_INIT     = 3'd0;
  localparam logic [CODE_W-1:0] M_CHARGING = 3'd1;
  localparam logic [CODE_W-1:0] M_READY    = 3'd2;
  localparam logic [CODE_W-1:0] M_BOOSTING = 3'd3;
  localparam logic [CODE_W-1:0] M_COOLDOWN = 3'd4;
  localparam logic [CODE_W-1:0] M_FAULT    = 3'd5;

  // fault codes
  localparam logic [CODE_W-1:0] F_NONE    = 3'd0;
  localparam logic [CODE_W-1:0] F_UNDER   = 3'd1;
  localparam logic [CODE_W-1:0] F_OVER    = 3'd2;
  localparam logic [CODE_W-1:0] F_BANK    = 3'd3;
  localparam logic [CODE_W-1:0] F_CURRENT = 3'd4;
  localparam logic [CODE_W-1:0] F_TIMEOUT = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] R_AC_LOW      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] R_AC_HIGH     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] R_BANK_CHG    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] R_BANK_MAX    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] R_MOTOR_START = 4'd4;
  localparam logic [CFG_IDX_W-1:0] R_CURRENT_MAX = 4'd5;
  localparam logic [CFG_IDX_W-1:0] R_CHG_TIMEOUT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] R_BOOST_LIMIT = 4'd7;

  // compare operations of the shared comparator, issued in this order
  localparam int NUM_CMP  = 12;
  localparam int CMP_OP_W = $clog2(NUM_CMP);
  typedef logic [CMP_OP_W-1:0] cmp_op_t;
  localparam cmp_op_t C_AC_UNDER  = 4'd0;
  localparam cmp_op_t C_AC_OVER   = 4'd1;
  localparam cmp_op_t C_VP_OVER   = 4'd2;
  localparam cmp_op_t C_VN_OVER   = 4'd3;
  localparam cmp_op_t C_IL_OVER   = 4'd4;
  localparam cmp_op_t C_MOTOR     = 4'd5;
  localparam cmp_op_t C_VP_CHG    = 4'd6;
  localparam cmp_op_t C_VN_CHG    = 4'd7;
  localparam cmp_op_t C_T_CHARGE  = 4'd8;
  localparam cmp_op_t C_T_BOOST   = 4'd9;
  localparam cmp_op_t C_T_STARTUP = 4'd10;
  localparam cmp_op_t C_T_COOL    = 4'd11;
  localparam cmp_op_t C_LAST      = cmp_op_t'(NUM_CMP - 1);

  typedef struct packed {
    logic [ADC_W-1:0] ac;
    logic [ADC_W-1:0] vp;
    logic [ADC_W-1:0] vn;
    logic [ADC_W-1:0] il;
  } samples_t;

  typedef struct packed {
    logic [ADC_W-1:0]  ac_low;
    logic [ADC_W-1:0]  ac_high;
    logic [ADC_W-1:0]  bank_chg;
    logic [ADC_W-1:0]  bank_max;
    logic [ADC_W-1:0]  motor_start;
    logic [ADC_W-1:0]  current_max;
    logic [TIME_W-1:0] chg_timeout;
    logic [TIME_W-1:0] boost_limit;
  } limits_t;

  // time base view handed to the sequencer
  typedef struct packed {
    logic [STAMP_W-1:0] now;
    logic               charge_blink;
    logic               boost_blink;
    logic               fault_blink;
  } timebase_t;

endpackage

>>> hdl/sca_if.sv
// ----------------------------------------------------------------------------
// sca_if
// Valid/ready channels of the controller: sample words, result words and
// configuration writes.
// ----------------------------------------------------------------------------
interface sca_in_if;
  import sca_pkg::*;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] ac_sample;
  logic [ADC_W-1:0] pos_bank_sample;
  logic [ADC_W-1:0] neg_bank_sample;
  logic [ADC_W-1:0] load_current_sample;
  logic             zero_cross;

  modport source (output valid, ac_sample, pos_bank_sample, neg_bank_sample,
                  load_current_sample, zero_cross, input ready);
  modport sink   (input valid, ac_sample, pos_bank_sample, neg_bank_sample,
                  load_current_sample, zero_cross, output ready);
endinterface

interface sca_out_if;
  import sca_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pos_duty;
  logic [DUTY_W-1:0] neg_duty;
  logic              pos_charge_on;
  logic              neg_charge_on;
  logic              status_led;
  logic [CODE_W-1:0] mode_out;
  logic [CODE_W-1:0] fault_out;

  modport source (output valid, pos_duty, neg_duty, pos_charge_on, neg_charge_on,
                  status_led, mode_out, fault_out, input ready);
  modport sink   (input valid, pos_duty, neg_duty, pos_charge_on, neg_charge_on,
                  status_led, mode_out, fault_out, output ready);
endinterface

interface sca_cfg_if;
  import sca_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/supercap_start_assist_controller.sv
// ----------------------------------------------------------------------------
// supercap_start_assist_controller
// Per-millisecond supervisor for a supercap motor start assist: safety
// limits, charge/ready/boost/cooldown sequencing, PWM drive and status LED.
// ----------------------------------------------------------------------------
// Each sample word is accepted in the idle state; the twelve checks then run one
// per cycle through a single shared comparator, and the update state commits.
// A new sample word is accepted only after the previous one has committed.
// A result waiting at the output does not block the next sample word; the
// commit waits until the output register is free.
// Reset (rst_n low, synchronous): mode init, no fault, counters and drives
// zero, limits back to their default values.
module supercap_start_assist_controller (
  input  logic  clk,
  input  logic  rst_n,
  sca_in_if.sink    in_ch,
  sca_out_if.source out_ch,
  sca_cfg_if.sink   cfg_ch
);
  import sca_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } seq_state_t;

  seq_state_t         state_r, state_nxt;
  cmp_op_t            step_r;
  logic [NUM_CMP-1:0] flags_r;
  logic               gt;

  samples_t           smp_r;
  logic               zc_r;
  logic [STAMP_W-1:0] elapsed_r;
  limits_t            lim_r;
  timebase_t          tb;

  logic [CODE_W-1:0]  mode_r, mode_nxt;
  logic [CODE_W-1:0]  fault_r, fault_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [DUTY_W-1:0]  boost_r, boost_nxt;
  logic               pend_r, pend_nxt;
  logic               pol_r, pol_nxt;
  logic [DUTY_W-1:0]  dpos_r, dpos_nxt;
  logic [DUTY_W-1:0]  dneg_r, dneg_nxt;
  logic [1:0]         chg_r, chg_nxt;
  logic               led_r, led_nxt;
  logic               out_valid_r;

  logic in_fire;
  logic commit;
  logic unsafe;
  logic [DUTY_W-1:0] lvl;
  logic [DUTY_W-1:0] duty;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign commit  = (state_r == ST_UPD) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  sca_cmp u_cmp (
    .op      (step_r),
    .smp     (smp_r),
    .lim     (lim_r),
    .elapsed (elapsed_r),
    .gt      (gt)
  );

  sca_timebase u_tb (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (commit),
    .fault_code (fault_r),
    .tb         (tb)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.ac_low      <= ADC_W'(1000);
      lim_r.ac_high     <= ADC_W'(3000);
      lim_r.bank_chg    <= ADC_W'(3000);
      lim_r.bank_max    <= ADC_W'(3500);
      lim_r.motor_start <= ADC_W'(1550);
      lim_r.current_max <= ADC_W'(4095);
      lim_r.chg_timeout <= TIME_W'(60000);
      lim_r.boost_limit <= TIME_W'(3000);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        R_AC_LOW:      lim_r.ac_low      <= cfg_ch.data[ADC_W-1:0];
        R_AC_HIGH:     lim_r.ac_high     <= cfg_ch.data[ADC_W-1:0];
        R_BANK_CHG:    lim_r.bank_chg    <= cfg_ch.data[ADC_W-1:0];
        R_BANK_MAX:    lim_r.bank_max    <= cfg_ch.data[ADC_W-1:0];
        R_MOTOR_START: lim_r.motor_start <= cfg_ch.data[ADC_W-1:0];
        R_CURRENT_MAX: lim_r.current_max <= cfg_ch.data[ADC_W-1:0];
        R_CHG_TIMEOUT: lim_r.chg_timeout <= cfg_ch.data;
        R_BOOST_LIMIT: lim_r.boost_limit <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CMP;
      ST_CMP:  if (step_r == C_LAST) state_nxt = ST_UPD;
      ST_UPD:  if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CMP) begin
        step_r <= (step_r == C_LAST) ? '0 : step_r + 1'b1;
      end
    end
  end

  // latch the sample word and the time since the mode was entered
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r.ac  <= in_ch.ac_sample;
      smp_r.vp  <= in_ch.pos_bank_sample;
      smp_r.vn  <= in_ch.neg_bank_sample;
      smp_r.il  <= in_ch.load_current_sample;
      zc_r      <= in_ch.zero_cross;
      elapsed_r <= tb.now - stamp_r;
    end
    if (state_r == ST_CMP) begin
      flags_r[step_r] <= gt;
    end
  end

  // next controller state from the collected check results
  always_comb begin
    mode_nxt  = mode_r;
    fault_nxt = fault_r;
    stamp_nxt = stamp_r;
    boost_nxt = boost_r;
    pol_nxt   = pol_r ^ zc_r;
    pend_nxt  = pend_r | zc_r;
    dpos_nxt  = dpos_r;
    dneg_nxt  = dneg_r;
    chg_nxt   = chg_r;
    led_nxt   = led_r;
    lvl       = boost_r;
    duty      = '0;

    unsafe = (mode_r != M_FAULT) && (mode_r != M_INIT) &&
             (flags_r[C_AC_UNDER] || flags_r[C_AC_OVER] || flags_r[C_VP_OVER] ||
              flags_r[C_VN_OVER] || flags_r[C_IL_OVER]);

    if (unsafe) begin
      mode_nxt = M_FAULT;
      dpos_nxt = '0;
      dneg_nxt = '0;
      chg_nxt  = 2'b00;
      priority if (flags_r[C_AC_UNDER])                      fault_nxt = F_UNDER;
      else if (flags_r[C_AC_OVER])                           fault_nxt = F_OVER;
      else if (flags_r[C_VP_OVER] || flags_r[C_VN_OVER])     fault_nxt = F_BANK;
      else                                                   fault_nxt = F_CURRENT;
    end else begin
      unique case (mode_r)
        M_INIT: begin
          mode_nxt  = M_CHARGING;
          stamp_nxt = tb.now;
          led_nxt   = 1'b0;
        end
        M_CHARGING: begin
          chg_nxt = 2'b11;
          led_nxt = tb.charge_blink;
          if (flags_r[C_VP_CHG] && flags_r[C_VN_CHG]) begin
            mode_nxt  = M_READY;
            stamp_nxt = tb.now;
          end else if (flags_r[C_T_CHARGE]) begin
            mode_nxt  = M_FAULT;
            fault_nxt = F_TIMEOUT;
            dpos_nxt  = '0;
            dneg_nxt  = '0;
            chg_nxt   = 2'b00;
          end
        end
        M_READY: begin
          chg_nxt = 2'b11;
          led_nxt = 1'b1;
          if (flags_r[C_MOTOR]) begin
            mode_nxt  = M_BOOSTING;
            stamp_nxt = tb.now;
            boost_nxt = BOOST_START;
            chg_nxt   = 2'b00;
          end
        end
        M_BOOSTING: begin
          // consume one pending crossing and ramp the level
          if (pend_nxt) begin
            pend_nxt = 1'b0;
            if (boost_r < BOOST_TOP) lvl = boost_r + BOOST_STEP;
          end
          boost_nxt = lvl;
          duty = (lvl > DUTY_MAX) ? DUTY_MAX : lvl;
          if (pol_nxt) begin
            dpos_nxt = duty;
            dneg_nxt = '0;
          end else begin
            dpos_nxt = '0;
            dneg_nxt = duty;
          end
          led_nxt = tb.boost_blink;
          if (flags_r[C_T_BOOST] || (!flags_r[C_MOTOR] && flags_r[C_T_STARTUP])) begin
            mode_nxt  = M_COOLDOWN;
            stamp_nxt = tb.now;
            dpos_nxt  = '0;
            dneg_nxt  = '0;
          end
        end
        M_COOLDOWN: begin
          dpos_nxt = '0;
          dneg_nxt = '0;
          led_nxt  = 1'b0;
          if (flags_r[C_T_COOL]) begin
            mode_nxt  = M_CHARGING;
            stamp_nxt = tb.now;
          end
        end
        default: begin
          dpos_nxt = '0;
          dneg_nxt = '0;
          chg_nxt  = 2'b00;
          led_nxt  = tb.fault_blink;
        end
      endcase
    end
  end

  // controller state doubles as the output register: it only moves on commit,
  // which waits for the output slot to be free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_INIT;
      fault_r     <= F_NONE;
      stamp_r     <= '0;
      boost_r     <= '0;
      pend_r      <= 1'b0;
      pol_r       <= 1'b0;
      dpos_r      <= '0;
      dneg_r      <= '0;
      chg_r       <= 2'b00;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        mode_r  <= mode_nxt;
        fault_r <= fault_nxt;
        stamp_r <= stamp_nxt;
        boost_r <= boost_nxt;
        pend_r  <= pend_nxt;
        pol_r   <= pol_nxt;
        dpos_r  <= dpos_nxt;
        dneg_r  <= dneg_nxt;
        chg_r   <= chg_nxt;
        led_r   <= led_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pos_duty      = dpos_r;
  assign out_ch.neg_duty      = dneg_r;
  assign out_ch.pos_charge_on = chg_r[0];
  assign out_ch.neg_charge_on = chg_r[1];
  assign out_ch.status_led    = led_r;
  assign out_ch.mode_out      = mode_r;
  assign out_ch.fault_out     = fault_r;

endmodule

>>> hdl/sca_cmp.sv
// ----------------------------------------------------------------------------
// sca_cmp
// Shared magnitude comparator: picks both operands for the requested check
// and reports a > b.
// ----------------------------------------------------------------------------
module sca_cmp (
  input  sca_pkg::cmp_op_t                op,
  input  sca_pkg::samples_t               smp,
  input  sca_pkg::limits_t                lim,
  input  logic [sca_pkg::STAMP_W-1:0]     elapsed,
  output logic                            gt
);
  import sca_pkg::*;

  logic [STAMP_W-1:0] opa;
  logic [STAMP_W-1:0] opb;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (op)
      C_AC_UNDER: begin
        opa = STAMP_W'(lim.ac_low);
        opb = STAMP_W'(smp.ac);
      end
      C_AC_OVER: begin
        opa = STAMP_W'(smp.ac);
        opb = STAMP_W'(lim.ac_high);
      end
      C_VP_OVER: begin
        opa = STAMP_W'(smp.vp);
        opb = STAMP_W'(lim.bank_max);
      end
      C_VN_OVER: begin
        opa = STAMP_W'(smp.vn);
        opb = STAMP_W'(lim.bank_max);
      end
      C_IL_OVER: begin
        opa = STAMP_W'(smp.il);
        opb = STAMP_W'(lim.current_max);
      end
      C_MOTOR: begin
        opa = STAMP_W'(smp.il);
        opb = STAMP_W'(lim.motor_start);
      end
      C_VP_CHG: begin
        opa = STAMP_W'(smp.vp);
        opb = STAMP_W'(lim.bank_chg);
      end
      C_VN_CHG: begin
        opa = STAMP_W'(smp.vn);
        opb = STAMP_W'(lim.bank_chg);
      end
      C_T_CHARGE: begin
        opa = elapsed;
        opb = STAMP_W'(lim.chg_timeout);
      end
      C_T_BOOST: begin
        opa = elapsed;
        opb = STAMP_W'(lim.boost_limit);
      end
      C_T_STARTUP: begin
        opa = elapsed;
        opb = STAMP_W'(STARTUP_WINDOW_MS);
      end
      C_T_COOL: begin
        opa = elapsed;
        opb = STAMP_W'(COOLDOWN_MS);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign gt = opa > opb;

endmodule

>>> hdl/sca_timebase.sv
// ----------------------------------------------------------------------------
// sca_timebase
// Millisecond counter with running quotient/remainder trackers for the LED
// blink periods, so no divider is needed.
// ----------------------------------------------------------------------------
module sca_timebase (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [sca_pkg::CODE_W-1:0]  fault_code,
  output sca_pkg::timebase_t          tb
);
  import sca_pkg::*;

  logic [STAMP_W-1:0]     ms_r;
  logic [CHG_REM_W-1:0]   chg_rem_r;
  logic                   chg_par_r;
  logic [BOOST_REM_W-1:0] boost_rem_r;
  logic                   boost_par_r;
  logic [FAULT_REM_W-1:0] fault_rem_r;
  // quotient of now/200 modulo 2..6
  logic                   q_m2_r;
  logic [1:0]             q_m3_r;
  logic [1:0]             q_m4_r;
  logic [2:0]             q_m5_r;
  logic [2:0]             q_m6_r;
  logic                   fault_led;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r        <= '0;
      chg_rem_r   <= '0;
      chg_par_r   <= 1'b0;
      boost_rem_r <= '0;
      boost_par_r <= 1'b0;
      fault_rem_r <= '0;
      q_m2_r      <= '0;
      q_m3_r      <= '0;
      q_m4_r      <= '0;
      q_m5_r      <= '0;
      q_m6_r      <= '0;
    end else if (advance) begin
      if (ms_r == '1) begin
        // counter wraps: every quotient restarts at zero
        ms_r        <= '0;
        chg_rem_r   <= '0;
        chg_par_r   <= 1'b0;
        boost_rem_r <= '0;
        boost_par_r <= 1'b0;
        fault_rem_r <= '0;
        q_m2_r      <= '0;
        q_m3_r      <= '0;
        q_m4_r      <= '0;
        q_m5_r      <= '0;
        q_m6_r      <= '0;
      end else begin
        ms_r <= ms_r + 1'b1;
        if (chg_rem_r == CHG_REM_W'(CHARGE_BLINK_MS - 1)) begin
          chg_rem_r <= '0;
          chg_par_r <= ~chg_par_r;
        end else begin
          chg_rem_r <= chg_rem_r + 1'b1;
        end
        if (boost_rem_r == BOOST_REM_W'(BOOST_BLINK_MS - 1)) begin
          boost_rem_r <= '0;
          boost_par_r <= ~boost_par_r;
        end else begin
          boost_rem_r <= boost_rem_r + 1'b1;
        end
        if (fault_rem_r == FAULT_REM_W'(FAULT_BLINK_MS - 1)) begin
          fault_rem_r <= '0;
          q_m2_r      <= ~q_m2_r;
          q_m3_r      <= (q_m3_r == 2'd2) ? 2'd0 : q_m3_r + 2'd1;
          q_m4_r      <= q_m4_r + 2'd1;
          q_m5_r      <= (q_m5_r == 3'd4) ? 3'd0 : q_m5_r + 3'd1;
          q_m6_r      <= (q_m6_r == 3'd5) ? 3'd0 : q_m6_r + 3'd1;
        end else begin
          fault_rem_r <= fault_rem_r + 1'b1;
        end
      end
    end
  end

  // LED on when the 200 ms period index is a multiple of fault_code + 1
  always_comb begin
    unique case (fault_code)
      F_UNDER:   fault_led = (q_m2_r == 1'b0);
      F_OVER:    fault_led = (q_m3_r == 2'd0);
      F_BANK:    fault_led = (q_m4_r == 2'd0);
      F_CURRENT: fault_led = (q_m5_r == 3'd0);
      F_TIMEOUT: fault_led = (q_m6_r == 3'd0);
      default:   fault_led = 1'b1;
    endcase
  end

  assign tb.now          = ms_r;
  assign tb.charge_blink = chg_par_r;
  assign tb.boost_blink  = boost_par_r;
  assign tb.fault_blink  = fault_led;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the supercap start-assist controller. Sample words
// are offered through valid/ready with random gaps. Each accepted word runs
// through a cycle-free copy of the millisecond supervisor, and the status
// word that comes back is compared field by field. The run opens with a
// short scripted walk from init to boosting. Mode-aware random traffic then
// takes the block through charging, ready, boost, cooldown and back. Open
// limits with extreme samples follow, and then noise under the trip limits
// that latches a fault.
// ----------------------------------------------------------------------------
module tb_top;
  import sca_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_GAP      = 10;
  localparam int PAD_W        = TIME_W - ADC_W;

  localparam logic [CFG_IDX_W-1:0] R_UNMAPPED = 4'd12;

  localparam logic [STAMP_W-1:0] BLINK_CHG_MS   = 500;
  localparam logic [STAMP_W-1:0] BLINK_BOOST_MS = 50;
  localparam logic [STAMP_W-1:0] BLINK_FAULT_MS = 200;
  localparam logic [DUTY_W-1:0]  RAMP_START = DUTY_W'(PWM_FULL_SCALE / 2);
  localparam logic [DUTY_W-1:0]  RAMP_STEP  = DUTY_W'(PWM_FULL_SCALE / 20);
  localparam logic [DUTY_W-1:0]  RAMP_CEIL  = DUTY_W'(PWM_FULL_SCALE * 8 / 10);
  localparam logic [DUTY_W-1:0]  DUTY_CLAMP = DUTY_W'(PWM_FULL_SCALE);

  localparam limits_t DEFAULT_LIMITS = '{12'd1000, 12'd3000, 12'd3000, 12'd3500,
                                         12'd1550, 12'd4095, 22'd60000, 22'd3000};
  localparam limits_t TIGHT_LIMITS   = '{12'd600, 12'd3400, 12'd2500, 12'd3800,
                                         12'd1200, 12'd3900, 22'd300, 22'd40};
  localparam limits_t OPEN_LIMITS    = '{12'd0, 12'd4095, 12'd4095, 12'd4095,
                                         12'd0, 12'd4095, 22'd4194303, 22'd0};
  localparam limits_t TRIP_LIMITS    = '{12'd1000, 12'd3000, 12'd3000, 12'd3500,
                                         12'd1550, 12'd3000, 22'd0, 22'd3000};

  typedef struct packed {
    samples_t s;
    logic     zc;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pos_duty;
    logic [DUTY_W-1:0] neg_duty;
    logic              pos_chg;
    logic              neg_chg;
    logic              led;
    logic [CODE_W-1:0] mode;
    logic [CODE_W-1:0] fault;
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0]  mode;
    logic [CODE_W-1:0]  fault;
    logic [STAMP_W-1:0] ms;
    logic [STAMP_W-1:0] stamp;
    logic [DUTY_W-1:0]  ramp;
    logic [DUTY_W-1:0]  dpos;
    logic [DUTY_W-1:0]  dneg;
    logic               pending;
    logic               polarity;
    logic [1:0]         charge;
    logic               led;
  } sup_state_t;

  typedef struct packed {
    logic [ADC_W-1:0] ac;
    logic [ADC_W-1:0] vp;
    logic [ADC_W-1:0] vn;
    logic [ADC_W-1:0] il;
    logic             zc;
    logic             typed;
    status_t          want;
  } script_row_t;

  // walk from init to boosting: limit boundaries, ramp up to its ceiling,
  // polarity steering and a crossing held over from charging
  script_row_t script [17] = '{
    '{12'd0,    12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b1,
      '{10'd0, 10'd0, 1'b0, 1'b0, 1'b0, M_CHARGING, F_NONE}},
    '{12'd1000, 12'd0,    12'd0,    12'd0,    1'b1, 1'b1,
      '{10'd0, 10'd0, 1'b1, 1'b1, 1'b0, M_CHARGING, F_NONE}},
    '{12'd3000, 12'd3000, 12'd3500, 12'd4095, 1'b0, 1'b0, '0},
    '{12'd2048, 12'd3001, 12'd3001, 12'd100,  1'b0, 1'b0, '0},
    '{12'd2048, 12'd3200, 12'd3200, 12'd1550, 1'b0, 1'b0, '0},
    '{12'd2048, 12'd3200, 12'd3200, 12'd1551, 1'b0, 1'b0, '0},
    '{12'd1500, 12'd2000, 12'd2000, 12'd2000, 1'b0, 1'b0, '0},
    '{12'd1500, 12'd2000, 12'd2000, 12'd2000, 1'b1, 1'b0, '0},
    '{12'd1500, 12'd2000, 12'd2000, 12'd2000, 1'b1, 1'b0, '0},
    '{12'd1500, 12'd2000, 12'd2000, 12'd2000, 1'b0, 1'b0, '0},
    '{12'd2500, 12'd1000, 12'd1000, 12'd3000, 1'b1, 1'b0, '0},
    '{12'd2500, 12'd1000, 12'd1000, 12'd3000, 1'b1, 1'b0, '0},
    '{12'd2500, 12'd1000, 12'd1000, 12'd3000, 1'b1, 1'b0, '0},
    '{12'd2500, 12'd1000, 12'd1000, 12'd3000, 1'b1, 1'b0, '0},
    '{12'd2500, 12'd1000, 12'd1000, 12'd0,    1'b0, 1'b0, '0},
    '{12'd1000, 12'd3500, 12'd3500, 12'd4095, 1'b1, 1'b0, '0},
    '{12'd3000, 12'd0,    12'd0,    12'd1551, 1'b0, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  sca_in_if  in_bus ();
  sca_out_if out_bus ();
  sca_cfg_if cfg_bus ();

  supercap_start_assist_controller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  sup_state_t st;
  limits_t    lim;
  status_t    status_due [$];
  int         bad_fields;
  int         results_taken;
  int         cycle_count;
  int         src_run;
  int         snk_run;
  bit         src_calm;
  bit         snk_calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // gaps come in runs: some runs idle at random, others stream back to back
  function automatic int draw_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [ADC_W-1:0] pick_in(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0: return ADC_W'(lo);
      1: return ADC_W'(hi);
      default: return ADC_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [ADC_W-1:0] wild_sample();
    if ($urandom_range(0, 3) == 0) begin
      return ($urandom_range(0, 1) == 1) ? {ADC_W{1'b1}} : '0;
    end
    return ADC_W'($urandom);
  endfunction

  // safe samples steered by the current mode (wild ones when noisy): charge the
  // banks, start the motor, keep it running through most of the boost
  function automatic tick_t make_tick(input bit noisy);
    tick_t t;
    int    quiet;
    bit    surge_ok;
    if (noisy) begin
      t.s.ac = wild_sample();
      t.s.vp = wild_sample();
      t.s.vn = wild_sample();
      t.s.il = wild_sample();
      t.zc = 1'($urandom_range(0, 1));
      return t;
    end
    surge_ok = lim.motor_start < lim.current_max;
    quiet = surge_ok ? int'(lim.motor_start) : int'(lim.current_max);
    t.s.ac = pick_in(lim.ac_low, lim.ac_high);
    t.s.vp = pick_in(0, lim.bank_max);
    t.s.vn = pick_in(0, lim.bank_max);
    t.s.il = pick_in(0, quiet);
    t.zc = ($urandom_range(0, 7) == 0);
    case (st.mode)
      M_CHARGING: begin
        if ($urandom_range(0, 7) == 0 && lim.bank_chg < lim.bank_max) begin
          t.s.vp = pick_in(lim.bank_chg + 1, lim.bank_max);
          t.s.vn = pick_in(lim.bank_chg + 1, lim.bank_max);
        end
      end
      M_READY: begin
        if ($urandom_range(0, 5) == 0 && surge_ok) begin
          t.s.il = pick_in(lim.motor_start + 1, lim.current_max);
        end
      end
      M_BOOSTING: begin
        if ($urandom_range(0, 3) != 0 && surge_ok) begin
          t.s.il = pick_in(lim.motor_start + 1, lim.current_max);
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic advance_supervisor(input tick_t t, output status_t r);
    logic [STAMP_W-1:0] now;
    logic [STAMP_W-1:0] quo;
    logic [CODE_W-1:0]  hit;
    logic               motor;
    now = st.ms;
    hit = F_NONE;
    if (t.zc) begin
      st.polarity = ~st.polarity;
      st.pending = 1'b1;
    end
    if (st.mode != M_FAULT && st.mode != M_INIT) begin
      if (t.s.ac < lim.ac_low) hit = F_UNDER;
      else if (t.s.ac > lim.ac_high) hit = F_OVER;
      else if (t.s.vp > lim.bank_max || t.s.vn > lim.bank_max) hit = F_BANK;
      else if (t.s.il > lim.current_max) hit = F_CURRENT;
    end
    if (hit != F_NONE) begin
      // latch and skip the rest of the tick; the LED keeps its level
      st.fault = hit;
      st.mode = M_FAULT;
      st.dpos = '0;
      st.dneg = '0;
      st.charge = '0;
    end else begin
      motor = t.s.il > lim.motor_start;
      case (st.mode)
        M_INIT: begin
          st.mode = M_CHARGING;
          st.stamp = now;
          st.led = 1'b0;
        end
        M_CHARGING: begin
          st.charge = 2'b11;
          quo = now / BLINK_CHG_MS;
          st.led = quo[0];
          if (t.s.vp > lim.bank_chg && t.s.vn > lim.bank_chg) begin
            st.mode = M_READY;
            st.stamp = now;
          end
          if (STAMP_W'(now - st.stamp) > STAMP_W'(lim.chg_timeout)) begin
            st.fault = F_TIMEOUT;
            st.mode = M_FAULT;
            st.dpos = '0;
            st.dneg = '0;
            st.charge = '0;
          end
        end
        M_READY: begin
          st.charge = 2'b11;
          st.led = 1'b1;
          if (motor) begin
            st.mode = M_BOOSTING;
            st.stamp = now;
            st.ramp = RAMP_START;
            st.charge = '0;
          end
        end
        M_BOOSTING: begin
          if (st.pending) begin
            st.pending = 1'b0;
            if (st.ramp < RAMP_CEIL) st.ramp = st.ramp + RAMP_STEP;
          end
          if (st.polarity) begin
            st.dpos = (st.ramp > DUTY_CLAMP) ? DUTY_CLAMP : st.ramp;
            st.dneg = '0;
          end else begin
            st.dpos = '0;
            st.dneg = (st.ramp > DUTY_CLAMP) ? DUTY_CLAMP : st.ramp;
          end
          quo = now / BLINK_BOOST_MS;
          st.led = quo[0];
          if (STAMP_W'(now - st.stamp) > STAMP_W'(lim.boost_limit)) begin
            st.mode = M_COOLDOWN;
            st.stamp = now;
            st.dpos = '0;
            st.dneg = '0;
          end
          if (!motor && STAMP_W'(now - st.stamp) > STAMP_W'(STARTUP_WINDOW_MS)) begin
            st.mode = M_COOLDOWN;
            st.stamp = now;
            st.dpos = '0;
            st.dneg = '0;
          end
        end
        M_COOLDOWN: begin
          st.dpos = '0;
          st.dneg = '0;
          st.led = 1'b0;
          if (STAMP_W'(now - st.stamp) > STAMP_W'(COOLDOWN_MS)) begin
            st.mode = M_CHARGING;
            st.stamp = now;
          end
        end
        default: begin
          st.dpos = '0;
          st.dneg = '0;
          st.charge = '0;
          quo = now / BLINK_FAULT_MS;
          st.led = ((quo % (STAMP_W'(st.fault) + STAMP_W'(1))) == '0);
        end
      endcase
    end
    st.ms = now + STAMP_W'(1);
    r = '{st.dpos, st.dneg, st.charge[0], st.charge[1], st.led, st.mode, st.fault};
  endtask

  task automatic push_sample(input tick_t t, input logic typed, input status_t want);
    int      gap;
    status_t predicted;
    gap = draw_gap(src_run, src_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid               <= 1'b1;
    in_bus.ac_sample           <= t.s.ac;
    in_bus.pos_bank_sample     <= t.s.vp;
    in_bus.neg_bank_sample     <= t.s.vn;
    in_bus.load_current_sample <= t.s.il;
    in_bus.zero_cross          <= t.zc;
    do @(posedge clk); while (!(in_bus.valid === 1'b1 && in_bus.ready === 1'b1));
    advance_supervisor(t, predicted);
    status_due.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!(cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1));
    case (idx)
      R_AC_LOW:      lim.ac_low      = val[ADC_W-1:0];
      R_AC_HIGH:     lim.ac_high     = val[ADC_W-1:0];
      R_BANK_CHG:    lim.bank_chg    = val[ADC_W-1:0];
      R_BANK_MAX:    lim.bank_max    = val[ADC_W-1:0];
      R_MOTOR_START: lim.motor_start = val[ADC_W-1:0];
      R_CURRENT_MAX: lim.current_max = val[ADC_W-1:0];
      R_CHG_TIMEOUT: lim.chg_timeout = val;
      R_BOOST_LIMIT: lim.boost_limit = val;
      default: ;
    endcase
  endtask

  // junk in the upper bits of the 12-bit registers must be dropped
  task automatic load_limits(input limits_t v);
    write_reg(R_AC_LOW,      {PAD_W'($urandom), v.ac_low});
    write_reg(R_AC_HIGH,     {PAD_W'($urandom), v.ac_high});
    write_reg(R_BANK_CHG,    {PAD_W'($urandom), v.bank_chg});
    write_reg(R_BANK_MAX,    {PAD_W'($urandom), v.bank_max});
    write_reg(R_MOTOR_START, {PAD_W'($urandom), v.motor_start});
    write_reg(R_CURRENT_MAX, {PAD_W'($urandom), v.current_max});
    write_reg(R_CHG_TIMEOUT, v.chg_timeout);
    write_reg(R_BOOST_LIMIT, v.boost_limit);
    write_reg(R_UNMAPPED,    TIME_W'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch on result %0d: expected %0d, got %0d",
             name, results_taken, want, got);
      bad_fields++;
    end
  endtask

  initial begin : result_sink
    int      gap;
    status_t seen;
    status_t want;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      gap = draw_gap(snk_run, snk_calm);
      // hold off long enough for the block to back up into its input
      if (results_taken == 250 || results_taken == 1300) gap = LONG_HOLD;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid === 1'b1 && out_bus.ready === 1'b1));
      results_taken++;
      seen = '{out_bus.pos_duty, out_bus.neg_duty, out_bus.pos_charge_on,
               out_bus.neg_charge_on, out_bus.status_led, out_bus.mode_out,
               out_bus.fault_out};
      if (status_due.size() == 0) begin
        $error("result word %0d arrived with nothing outstanding", results_taken);
        bad_fields++;
      end else begin
        want = status_due.pop_front();
        compare_field("pos_duty",      want.pos_duty, seen.pos_duty);
        compare_field("neg_duty",      want.neg_duty, seen.neg_duty);
        compare_field("pos_charge_on", want.pos_chg,  seen.pos_chg);
        compare_field("neg_charge_on", want.neg_chg,  seen.neg_chg);
        compare_field("status_led",    want.led,      seen.led);
        compare_field("mode_out",      want.mode,     seen.mode);
        compare_field("fault_out",     want.fault,    seen.fault);
      end
    end
  end

  initial begin : stimulus
    tick_t t;
    st = '0;
    st.mode = M_INIT;
    lim = DEFAULT_LIMITS;
    bad_fields = 0;
    results_taken = 0;
    src_run = 0;
    snk_run = 0;
    src_calm = 1'b0;
    snk_calm = 1'b0;
    rst_n <= 1'b0;
    in_bus.valid               <= 1'b0;
    in_bus.ac_sample           <= '0;
    in_bus.pos_bank_sample     <= '0;
    in_bus.neg_bank_sample     <= '0;
    in_bus.load_current_sample <= '0;
    in_bus.zero_cross          <= 1'b0;
    out_bus.ready              <= 1'b0;
    cfg_bus.valid              <= 1'b0;
    cfg_bus.index              <= '0;
    cfg_bus.data               <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      t.s = '{script[i].ac, script[i].vp, script[i].vn, script[i].il};
      t.zc = script[i].zc;
      push_sample(t, script[i].typed, script[i].want);
    end

    // default limits: finish the boost through the startup window
    repeat (500) push_sample(make_tick(1'b0), 1'b0, '0);
    settle();

    // tight limits: cooldown runs out, recharge, boost cut by its limit
    load_limits(TIGHT_LIMITS);
    repeat (1100) push_sample(make_tick(1'b0), 1'b0, '0);
    settle();

    // wide-open limits: any sample value is safe
    load_limits(OPEN_LIMITS);
    repeat (150) push_sample(make_tick(1'b1), 1'b0, '0);
    settle();

    // noise under the trip limits trips a fault, then watch the fault blink
    load_limits(TRIP_LIMITS);
    repeat (150) push_sample(make_tick(1'b1), 1'b0, '0);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> supercap_start_assist_controller.f
hdl/sca_pkg.sv
hdl/sca_if.sv
hdl/sca_cmp.sv
hdl/sca_timebase.sv
hdl/supercap_start_assist_controller.sv
tb/sv/tb_top.sv
